@@ rtl/mdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

	// input item kinds
	localparam logic [1:0] FUNC_CMD   = 2'd0;
	localparam logic [1:0] FUNC_DATA  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	// command bytes
	localparam logic [7:0] CMD_CONTRAST = 8'h81;
	localparam logic [7:0] CMD_ALL_OFF  = 8'hA4;
	localparam logic [7:0] CMD_ALL_ON   = 8'hA5;
	localparam logic [7:0] CMD_INV_OFF  = 8'hA6;
	localparam logic [7:0] CMD_INV_ON   = 8'hA7;
	localparam logic [7:0] CMD_DISP_OFF = 8'hAE;
	localparam logic [7:0] CMD_DISP_ON  = 8'hAF;

	localparam logic [7:0] CONTRAST_RESET = 8'hFF;
	localparam int         DIM_NUM        = 48;

	// widest frame store address over the parameter range
	localparam int STORE_AW    = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [3:0] {
		OP_CONTRAST,
		OP_ALL_ON,
		OP_ALL_OFF,
		OP_INV_ON,
		OP_INV_OFF,
		OP_DISP_ON,
		OP_DISP_OFF,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          value;
		logic [2:0]          row;
		logic                hit;
	} q_entry_t;

endpackage

`default_nettype wire

@@ rtl/mdc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdc_front #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          func,
	input  wire logic [7:0]          data_byte,
	input  wire logic [6:0]          pixel_x,
	input  wire logic [5:0]          pixel_y,
	output logic                     q_push,
	output mdc_pkg::q_entry_t        q_entry,
	input  wire logic                q_full
);

	localparam int PAGE_COUNT = PANEL_HEIGHT / 8;
	localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int SAW        = mdc_pkg::STORE_AW;

	logic              pending_q, pending_d;
	logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
	logic              wrapped_q, wrapped_d;

	logic              accept;
	logic [2:0]        page;
	logic              in_range;
	logic [SAW-1:0]    qaddr;
	logic              written;

	assign full   = q_full;
	assign accept = push && !q_full;

	// query address and whether that entry has been written since reset
	assign page     = pixel_y[5:3];
	assign in_range = (9'(pixel_x) < 9'(PANEL_WIDTH)) && (5'(page) < 5'(PAGE_COUNT));
	assign qaddr    = SAW'(page) * SAW'(PANEL_WIDTH) + SAW'(pixel_x);
	assign written  = wrapped_q || (qaddr < SAW'(wr_addr_q));

	always_comb begin
		pending_d     = pending_q;
		wr_addr_d     = wr_addr_q;
		wrapped_d     = wrapped_q;
		q_push        = 1'b0;
		q_entry.op    = mdc_pkg::OP_READ;
		q_entry.addr  = qaddr;
		q_entry.value = data_byte;
		q_entry.row   = pixel_y[2:0];
		q_entry.hit   = in_range && written;
		if (accept) begin
			unique case (func)
				mdc_pkg::FUNC_CMD: begin
					if (pending_q) begin
						pending_d  = 1'b0;
						q_push     = 1'b1;
						q_entry.op = mdc_pkg::OP_CONTRAST;
					end else begin
						q_push = 1'b1;
						unique case (data_byte)
							mdc_pkg::CMD_CONTRAST: begin
								pending_d = 1'b1;
								q_push    = 1'b0;
							end
							mdc_pkg::CMD_ALL_OFF:  q_entry.op = mdc_pkg::OP_ALL_OFF;
							mdc_pkg::CMD_ALL_ON:   q_entry.op = mdc_pkg::OP_ALL_ON;
							mdc_pkg::CMD_INV_OFF:  q_entry.op = mdc_pkg::OP_INV_OFF;
							mdc_pkg::CMD_INV_ON:   q_entry.op = mdc_pkg::OP_INV_ON;
							mdc_pkg::CMD_DISP_OFF: q_entry.op = mdc_pkg::OP_DISP_OFF;
							mdc_pkg::CMD_DISP_ON:  q_entry.op = mdc_pkg::OP_DISP_ON;
							default:               q_push     = 1'b0;
						endcase
					end
				end
				mdc_pkg::FUNC_DATA: begin
					q_push       = 1'b1;
					q_entry.op   = mdc_pkg::OP_WRITE;
					q_entry.addr = SAW'(wr_addr_q);
					// column/page walk is a linear sweep of the store
					if (wr_addr_q == ADDR_W'(STORE_SIZE - 1)) begin
						wr_addr_d = '0;
						wrapped_d = 1'b1;
					end else begin
						wr_addr_d = wr_addr_q + 1'b1;
					end
				end
				mdc_pkg::FUNC_QUERY: begin
					q_push     = 1'b1;
					q_entry.op = mdc_pkg::OP_READ;
				end
				default: q_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			wr_addr_q <= '0;
			wrapped_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			wr_addr_q <= wr_addr_d;
			wrapped_q <= wrapped_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/mdc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_push,
	input  mdc_pkg::q_entry_t       q_wdata,
	output logic                    q_full,
	input  wire logic               q_pop,
	output mdc_pkg::q_entry_t       q_rdata,
	output logic                    q_empty
);

	localparam int DEPTH = mdc_pkg::QUEUE_DEPTH;
	localparam int PW    = mdc_pkg::QPTR_W;

	mdc_pkg::q_entry_t slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_push, do_pop;

	assign q_full  = (count_q == (PW+1)'(DEPTH));
	assign q_empty = (count_q == '0);
	assign q_rdata = slot_q[rd_ptr_q];
	assign do_push = q_push && !q_full;
	assign do_pop  = q_pop && !q_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/mdc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mdc_back #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  mdc_pkg::q_entry_t       q_rdata,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic [7:0]              gray_level
);

	localparam int PAGE_COUNT = PANEL_HEIGHT / 8;
	localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	logic [7:0]        frame_q [STORE_SIZE];
	logic [ADDR_W-1:0] addr;
	logic              wr_en, rd_en;

	logic [7:0]        contrast_q;
	logic              all_on_q, inverse_q, enabled_q;

	logic              valid_s2, hit_s2;
	logic [2:0]        row_s2;
	logic [7:0]        rd_data_s2;

	logic              out_valid_q;
	logic [7:0]        gray_q;

	logic              s2_go, s2_free, take;
	logic [15:0]       dim_prod, dim_sum;
	logic [7:0]        fg, bg, level;
	logic              pix;

	assign s2_go   = valid_s2 && (!out_valid_q || pop);
	assign s2_free = !valid_s2 || s2_go;
	assign take    = !q_empty && s2_free;
	assign q_pop   = take;

	assign addr  = q_rdata.addr[ADDR_W-1:0];
	assign wr_en = take && (q_rdata.op == mdc_pkg::OP_WRITE);
	assign rd_en = take && (q_rdata.op == mdc_pkg::OP_READ);

	// single port frame store, read data registered into stage 2
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_q[addr] <= q_rdata.value;
		end
		if (rd_en) begin
			rd_data_s2 <= frame_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q <= mdc_pkg::CONTRAST_RESET;
			all_on_q   <= 1'b0;
			inverse_q  <= 1'b0;
			enabled_q  <= 1'b0;
		end else if (take) begin
			unique case (q_rdata.op)
				mdc_pkg::OP_CONTRAST: contrast_q <= q_rdata.value;
				mdc_pkg::OP_ALL_ON:   all_on_q   <= 1'b1;
				mdc_pkg::OP_ALL_OFF:  all_on_q   <= 1'b0;
				mdc_pkg::OP_INV_ON:   inverse_q  <= 1'b1;
				mdc_pkg::OP_INV_OFF:  inverse_q  <= 1'b0;
				mdc_pkg::OP_DISP_ON:  enabled_q  <= 1'b1;
				mdc_pkg::OP_DISP_OFF: enabled_q  <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rd_en) begin
			valid_s2 <= 1'b1;
		end else if (s2_go) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit_s2 <= q_rdata.hit;
			row_s2 <= q_rdata.row;
		end
	end

	// 48*c/255 as (p + p/256 + 1) / 256, exact for p below 65535
	assign dim_prod = 16'(contrast_q) * 16'(mdc_pkg::DIM_NUM);
	assign dim_sum  = dim_prod + (dim_prod >> 8) + 16'd1;

	always_comb begin
		fg  = enabled_q ? contrast_q : 8'd0;
		bg  = (!enabled_q || all_on_q) ? fg : dim_sum[15:8];
		pix = hit_s2 && rd_data_s2[row_s2];
		if (pix) begin
			level = inverse_q ? bg : fg;
		end else begin
			level = inverse_q ? fg : bg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			gray_q <= level;
		end
	end

	assign empty      = !out_valid_q;
	assign gray_level = gray_q;

endmodule

`default_nettype wire

@@ rtl/mono_display_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          beat
// input     in         push / full        func, data_byte, pixel_x, pixel_y
// result    out        empty / pop        gray_level
//
// one input beat per cycle sustained while full is low; a query's result passes through
// the queue write, the frame store read and the result register
// frame store is single ported: one write or one read per cycle from the back end
// arst_n clears control; store contents are tracked by a write sweep count, no clear pass
// a stalled result holds the back end; the 4-entry queue then fills and raises full

module mono_display_controller #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] func,
	input  wire logic [7:0] data_byte,
	input  wire logic [6:0] pixel_x,
	input  wire logic [5:0] pixel_y,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      gray_level
);

	logic              q_push, q_full, q_pop, q_empty;
	mdc_pkg::q_entry_t q_wdata, q_rdata;

	mdc_front #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.data_byte(data_byte),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.q_push   (q_push),
		.q_entry  (q_wdata),
		.q_full   (q_full)
	);

	mdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_wdata(q_wdata),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_rdata(q_rdata),
		.q_empty(q_empty)
	);

	mdc_back #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.gray_level(gray_level)
	);

`ifndef ASSERT_OFF
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_reset_no_result: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result shown during reset");

	a_result_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(!q_empty, 2))
		else $error("result appeared without a queued query");
`endif

endmodule

`default_nettype wire
